// ----- rtl/calendar_date_arithmetic_unit_macros.svh -----
// assertion macros shared by the date unit checker
`ifndef CALENDAR_DATE_ARITHMETIC_UNIT_MACROS_SVH
`define CALENDAR_DATE_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CDAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CDAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cdau_pkg.sv -----
// types, constants and calendar helper functions for the date arithmetic unit
package cdau_pkg;

    // field widths
    localparam int OFFSET_BITS = 16;
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int ORD_W       = 9;
    localparam int WDAY_W      = 3;

    // working widths
    localparam int DOY_W  = OFFSET_BITS + 2;
    localparam int TOT_W  = ((OFFSET_BITS > 17) ? OFFSET_BITS : 17) + 2;
    localparam int Q_W    = 8;
    localparam int LO_W   = 7;
    localparam int SUM_W  = 11;
    localparam int MP_W   = YEAR_W + 13;
    localparam int T4_W   = 15;
    localparam int QP_W   = T4_W + 16;
    localparam int MR_W   = 17;

    // year limits
    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    // month-count limits (year * 12 + month - 1)
    localparam logic signed [TOT_W-1:0] TOTAL_MIN = TOT_W'(12);
    localparam logic signed [TOT_W-1:0] TOTAL_MAX = TOT_W'(119999);

    localparam logic [MONTH_W-1:0] MONTHS   = 4'd12;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] MARCH    = 4'd3;
    localparam logic [LO_W-1:0]    LO_LAST  = 7'd99;
    localparam logic [ORD_W-1:0]   ORD_LAST = 9'd365;
    localparam logic [WDAY_W-1:0]  WDAY_LAST = 3'd6;

    // reciprocal constants: n / 100 = (n * 5243) >> 19, n / 3 = (n * 43691) >> 17
    localparam logic [12:0] RECIP100 = 13'd5243;
    localparam int          SH100    = 19;
    localparam logic [15:0] RECIP3   = 16'd43691;
    localparam int          SH3      = 17;

    // weekday bias keeps the sum positive
    localparam logic [SUM_W-1:0] WDAY_BIAS = 11'd700;

    typedef enum logic {
        ACT_DAYS   = 1'b0,
        ACT_MONTHS = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef struct packed {
        t_action                 action;
        logic [YEAR_W-1:0]       year;
        logic [MONTH_W-1:0]      month;
        logic [DAY_W-1:0]        day;
        logic signed [OFFSET_BITS-1:0] offset;
    } t_in_word;

    typedef struct packed {
        logic [YEAR_W-1:0]  new_year;
        logic [MONTH_W-1:0] new_month;
        logic [DAY_W-1:0]   new_day;
        logic [ORD_W-1:0]   ordinal_day;
        logic [WDAY_W-1:0]  weekday;
        t_status            status;
    } t_out_word;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SPLIT_MUL,
        S_SPLIT_REM,
        S_CHECK,
        S_STEP,
        S_MSRCH,
        S_MDIV,
        S_MREM,
        S_SPLIT2_MUL,
        S_SPLIT2_REM,
        S_CLAMP,
        S_ORD,
        S_WDAY,
        S_EMIT
    } t_state;

    // datapath commands
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SPLIT_MUL,
        OP_SPLIT_REM,
        OP_CHECK,
        OP_STEP,
        OP_MSRCH,
        OP_MDIV,
        OP_MREM,
        OP_CLAMP,
        OP_ORD,
        OP_WDAY,
        OP_FAIL_DATE,
        OP_FAIL_RANGE,
        OP_EMIT
    } t_dp_op;

    // datapath status back to the controller
    typedef struct packed {
        logic date_ok;
        logic is_month;
        logic step_more;
        logic step_fail;
        logic msrch_more;
        logic total_bad;
        logic out_free;
    } t_dp_stat;

    // leap test from year / 100 and year % 100
    function automatic logic is_leap(input logic [Q_W-1:0] q, input logic [LO_W-1:0] lo);
        return ((lo != '0) && (lo[1:0] == 2'b00)) || ((lo == '0) && (q[1:0] == 2'b00));
    endfunction

    // month length, zero for a month code outside 1..12
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // zero-based day of year of the first of each month, common year
    function automatic logic [ORD_W-1:0] month_first(input logic [MONTH_W-1:0] m);
        logic [ORD_W-1:0] first;
        case (m)
            4'd1:    first = 9'd0;
            4'd2:    first = 9'd31;
            4'd3:    first = 9'd59;
            4'd4:    first = 9'd90;
            4'd5:    first = 9'd120;
            4'd6:    first = 9'd151;
            4'd7:    first = 9'd181;
            4'd8:    first = 9'd212;
            4'd9:    first = 9'd243;
            4'd10:   first = 9'd273;
            4'd11:   first = 9'd304;
            4'd12:   first = 9'd334;
            default: first = 9'd0;
        endcase
        return first;
    endfunction

    function automatic logic [ORD_W-1:0] year_days(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    // (13 * m - 1) / 5 for the march-based month 1..12
    function automatic logic [DAY_W-1:0] gauss_month(input logic [MONTH_W-1:0] mg);
        logic [DAY_W-1:0] v;
        case (mg)
            4'd1:    v = 5'd2;
            4'd2:    v = 5'd5;
            4'd3:    v = 5'd7;
            4'd4:    v = 5'd10;
            4'd5:    v = 5'd12;
            4'd6:    v = 5'd15;
            4'd7:    v = 5'd18;
            4'd8:    v = 5'd20;
            4'd9:    v = 5'd23;
            4'd10:   v = 5'd25;
            4'd11:   v = 5'd28;
            4'd12:   v = 5'd31;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    // modulo 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [WDAY_W-1:0] mod7(input logic [9:0] s);
        logic [7:0] a;
        logic [4:0] b;
        logic [3:0] c;
        a = 8'(s[9:3]) + 8'(s[2:0]);
        b = 5'(a[7:3]) + 5'(a[2:0]);
        c = 4'(b[4:3]) + 4'(b[2:0]);
        return (c >= 4'd7) ? 3'(c - 4'd7) : c[2:0];
    endfunction

endpackage

// ----- rtl/calendar_date_arithmetic_unit.sv -----
// Gregorian date arithmetic: moves a date by days or months and returns the new date,
// its zero-based day of year and its weekday (0 = Sunday). One word is worked on at a
// time; the result sits in an output register, so the next word is taken as soon as
// the result is loaded there. A day move steps the working year one year per cycle
// (about 90 years for an offset of 32767 days), then walks the months of the final
// year in the month search (up to 11 months). Quotients by 100 and by 12 come from a
// reciprocal multiply. Status 1 flags an invalid input date, status 2 a result year
// outside 1..9999; both return the input date with day of year and weekday zero.
module calendar_date_arithmetic_unit
    import cdau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    // sequencer
    cdau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (dp_stat),
        .o_in_stall (o_in_stall),
        .o_op       (dp_op)
    );

    // arithmetic and result register
    cdau_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (dp_op),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/cdau_dp.sv -----
// datapath: input registers, year stepping, month search, split and weekday units
module cdau_dp
    import cdau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_op    i_op,
    input  t_in_word  i_in_data,
    input  logic      i_out_stall,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    output t_out_word o_out_data
);

    // captured input word
    t_action                       r_act;
    logic [YEAR_W-1:0]             r_y;
    logic [MONTH_W-1:0]            r_m;
    logic [DAY_W-1:0]              r_d;
    logic signed [OFFSET_BITS-1:0] r_off;

    // working year with its split into year / 100 and year % 100
    logic [YEAR_W-1:0] r_cy;
    logic [Q_W-1:0]    r_q;
    logic [LO_W-1:0]   r_lo;

    logic signed [DOY_W-1:0] r_doy;
    logic signed [TOT_W-1:0] r_total;
    logic [MONTH_W-1:0]      r_k;
    logic [ORD_W-1:0]        r_left;
    logic [MONTH_W-1:0]      r_mg;

    // result fields
    logic [YEAR_W-1:0]  r_ny;
    logic [MONTH_W-1:0] r_nm;
    logic [DAY_W-1:0]   r_nd;
    logic [ORD_W-1:0]   r_ord;
    logic [WDAY_W-1:0]  r_wd;
    t_status            r_status;

    logic      r_out_valid;
    t_out_word r_out_data;

    // combinational helpers
    logic                    leap, leap_dec;
    logic [ORD_W-1:0]        ylen, ylen_dec;
    logic signed [DOY_W-1:0] ylen_s, ylen_dec_s;
    logic [YEAR_W-1:0]       cy_inc, cy_dec;
    logic [Q_W-1:0]          q_inc, q_dec;
    logic [LO_W-1:0]         lo_inc, lo_dec;
    logic                    doy_hi, doy_neg;
    logic [DAY_W-1:0]        mlen_k, mlen_in, mlen_nm;
    logic [ORD_W-1:0]        mlen_k_w;
    logic [ORD_W-1:0]        ord_in, ord_res;
    logic signed [DOY_W-1:0] doy_start;
    logic signed [TOT_W-1:0] total_start;
    logic [MP_W-1:0]         prod100;
    logic [YEAR_W-1:0]       q100_x;
    logic [YEAR_W-1:0]       rem100;
    logic [T4_W-1:0]         t4;
    logic [QP_W-1:0]         prod3;
    logic [MR_W-1:0]         ny12, rem12;
    logic [SUM_W-1:0]        wsum_pos, wsum;
    logic                    out_free;

    // leap flags and year lengths for this year and the one before
    assign leap       = is_leap(r_q, r_lo);
    assign ylen       = year_days(leap);
    assign ylen_s     = {{(DOY_W-ORD_W){1'b0}}, ylen};
    assign cy_inc     = r_cy + 14'd1;
    assign cy_dec     = r_cy - 14'd1;
    assign q_inc      = (r_lo == LO_LAST) ? r_q + 8'd1 : r_q;
    assign lo_inc     = (r_lo == LO_LAST) ? '0 : r_lo + 7'd1;
    assign q_dec      = (r_lo == '0) ? r_q - 8'd1 : r_q;
    assign lo_dec     = (r_lo == '0) ? LO_LAST : r_lo - 7'd1;
    assign leap_dec   = is_leap(q_dec, lo_dec);
    assign ylen_dec   = year_days(leap_dec);
    assign ylen_dec_s = {{(DOY_W-ORD_W){1'b0}}, ylen_dec};

    // day-of-year still outside the working year
    assign doy_neg = r_doy[DOY_W-1];
    assign doy_hi  = !doy_neg && (r_doy >= ylen_s);

    // month search compare
    assign mlen_k   = month_days(r_k, leap);
    assign mlen_k_w = {{(ORD_W-DAY_W){1'b0}}, mlen_k};

    // start day of year plus offset, and start month count plus offset
    assign mlen_in   = month_days(r_m, leap);
    assign ord_in    = month_first(r_m) + {{(ORD_W-DAY_W){1'b0}}, r_d} - 9'd1
                     + {{(ORD_W-1){1'b0}}, (leap && (r_m >= MARCH))};
    assign doy_start = {{(DOY_W-ORD_W){1'b0}}, ord_in}
                     + {{(DOY_W-OFFSET_BITS){r_off[OFFSET_BITS-1]}}, r_off};
    assign total_start = TOT_W'({r_y, 3'b000}) + TOT_W'({r_y, 2'b00})
                       + TOT_W'(r_m - 4'd1)
                       + {{(TOT_W-OFFSET_BITS){r_off[OFFSET_BITS-1]}}, r_off};

    // year split: quotient by reciprocal, remainder by shift-add
    assign prod100 = MP_W'(r_cy) * MP_W'(RECIP100);
    assign q100_x  = YEAR_W'({r_q, 6'b000000}) + YEAR_W'({r_q, 5'b00000})
                   + YEAR_W'({r_q, 2'b00});
    assign rem100  = r_cy - q100_x;

    // month count divided by 12: drop two bits, then divide by 3
    assign t4    = r_total[T4_W+1:2];
    assign prod3 = QP_W'(t4) * QP_W'(RECIP3);
    assign ny12  = MR_W'({r_cy, 3'b000}) + MR_W'({r_cy, 2'b00});
    assign rem12 = r_total[MR_W-1:0] - ny12;

    // result ordinal and clamp limit
    assign mlen_nm = month_days(r_nm, leap);
    assign ord_res = month_first(r_nm) + {{(ORD_W-DAY_W){1'b0}}, r_nd} - 9'd1
                   + {{(ORD_W-1){1'b0}}, (leap && (r_nm >= MARCH))};

    // gauss weekday sum, always positive thanks to the bias
    assign wsum_pos = WDAY_BIAS + SUM_W'(r_lo >> 2) + SUM_W'(r_q >> 2)
                    + SUM_W'(gauss_month(r_mg)) + SUM_W'(r_lo) + SUM_W'(r_nd);
    assign wsum     = wsum_pos - SUM_W'({r_q, 1'b0});

    assign out_free = !r_out_valid || !i_out_stall;

    // status to the controller
    always_comb begin
        o_stat.date_ok    = (r_y >= YEAR_MIN) && (r_y <= YEAR_MAX) && (r_d != '0)
                          && (r_d <= mlen_in);
        o_stat.is_month   = (r_act == ACT_MONTHS);
        o_stat.step_more  = doy_hi || doy_neg;
        o_stat.step_fail  = (doy_hi && (r_cy == YEAR_MAX)) || (doy_neg && (r_cy == YEAR_MIN));
        o_stat.msrch_more = (r_k < MONTHS) && (r_left >= mlen_k_w);
        o_stat.total_bad  = (r_total < TOTAL_MIN) || (r_total > TOTAL_MAX);
        o_stat.out_free   = out_free;
    end

    // working registers, driven by the controller's command
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_act    <= i_in_data.action;
                r_y      <= i_in_data.year;
                r_m      <= i_in_data.month;
                r_d      <= i_in_data.day;
                r_off    <= i_in_data.offset;
                r_cy     <= i_in_data.year;
                r_status <= ST_OK;
            end
            OP_SPLIT_MUL: begin
                r_q <= prod100[MP_W-1:SH100];
            end
            OP_SPLIT_REM: begin
                r_lo <= rem100[LO_W-1:0];
            end
            OP_CHECK: begin
                r_doy   <= doy_start;
                r_total <= total_start;
            end
            OP_STEP: begin
                if (doy_hi) begin
                    r_doy <= r_doy - ylen_s;
                    r_cy  <= cy_inc;
                    r_q   <= q_inc;
                    r_lo  <= lo_inc;
                end else if (doy_neg) begin
                    r_doy <= r_doy + ylen_dec_s;
                    r_cy  <= cy_dec;
                    r_q   <= q_dec;
                    r_lo  <= lo_dec;
                end else begin
                    r_k    <= 4'd1;
                    r_left <= r_doy[ORD_W-1:0];
                    r_ny   <= r_cy;
                end
            end
            OP_MSRCH: begin
                if ((r_k < MONTHS) && (r_left >= mlen_k_w)) begin
                    r_left <= r_left - mlen_k_w;
                    r_k    <= r_k + 4'd1;
                end else begin
                    r_nm <= r_k;
                    r_nd <= r_left[DAY_W-1:0] + 5'd1;
                end
            end
            OP_MDIV: begin
                r_cy <= prod3[SH3+YEAR_W-1:SH3];
                r_ny <= prod3[SH3+YEAR_W-1:SH3];
            end
            OP_MREM: begin
                r_nm <= rem12[MONTH_W-1:0] + 4'd1;
            end
            OP_CLAMP: begin
                r_nd <= (r_d > mlen_nm) ? mlen_nm : r_d;
            end
            OP_ORD: begin
                r_ord <= ord_res;
                // january and february count in the previous year
                if (r_nm <= FEBRUARY) begin
                    r_mg <= r_nm + 4'd10;
                    r_cy <= cy_dec;
                    r_q  <= q_dec;
                    r_lo <= lo_dec;
                end else begin
                    r_mg <= r_nm - 4'd2;
                end
            end
            OP_WDAY: begin
                r_wd <= mod7(wsum[9:0]);
            end
            OP_FAIL_DATE, OP_FAIL_RANGE: begin
                r_status <= (i_op == OP_FAIL_DATE) ? ST_BAD_DATE : ST_RANGE;
                r_ny     <= r_y;
                r_nm     <= r_m;
                r_nd     <= r_d;
                r_ord    <= '0;
                r_wd     <= '0;
            end
            default: begin
            end
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_EMIT) begin
            r_out_data.new_year    <= r_ny;
            r_out_data.new_month   <= r_nm;
            r_out_data.new_day     <= r_nd;
            r_out_data.ordinal_day <= r_ord;
            r_out_data.weekday     <= r_wd;
            r_out_data.status      <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/cdau_ctrl.sv -----
// controller: sequences the datapath through split, stepping, search and weekday
module cdau_ctrl
    import cdau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_op   o_op
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // input side takes a word only when idle
    assign o_in_stall = (r_state != S_IDLE);

    // next state and command
    always_comb begin
        n_state = r_state;
        o_op    = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_SPLIT_MUL;
                end
            end
            S_SPLIT_MUL: begin
                o_op    = OP_SPLIT_MUL;
                n_state = S_SPLIT_REM;
            end
            S_SPLIT_REM: begin
                o_op    = OP_SPLIT_REM;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_stat.date_ok) begin
                    o_op    = OP_FAIL_DATE;
                    n_state = S_EMIT;
                end else begin
                    o_op    = OP_CHECK;
                    n_state = i_stat.is_month ? S_MDIV : S_STEP;
                end
            end
            S_STEP: begin
                if (i_stat.step_fail) begin
                    o_op    = OP_FAIL_RANGE;
                    n_state = S_EMIT;
                end else begin
                    o_op    = OP_STEP;
                    if (!i_stat.step_more) begin
                        n_state = S_MSRCH;
                    end
                end
            end
            S_MSRCH: begin
                o_op = OP_MSRCH;
                if (!i_stat.msrch_more) begin
                    n_state = S_ORD;
                end
            end
            S_MDIV: begin
                if (i_stat.total_bad) begin
                    o_op    = OP_FAIL_RANGE;
                    n_state = S_EMIT;
                end else begin
                    o_op    = OP_MDIV;
                    n_state = S_MREM;
                end
            end
            S_MREM: begin
                o_op    = OP_MREM;
                n_state = S_SPLIT2_MUL;
            end
            S_SPLIT2_MUL: begin
                o_op    = OP_SPLIT_MUL;
                n_state = S_SPLIT2_REM;
            end
            S_SPLIT2_REM: begin
                o_op    = OP_SPLIT_REM;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                o_op    = OP_CLAMP;
                n_state = S_ORD;
            end
            S_ORD: begin
                o_op    = OP_ORD;
                n_state = S_WDAY;
            end
            S_WDAY: begin
                o_op    = OP_WDAY;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_op    = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/cdau_checker.sv -----
// port-level checker for the date arithmetic unit, bound to the top level
`include "calendar_date_arithmetic_unit_macros.svh"

module cdau_checker
    import cdau_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_data
);

    // a stalled result word stays put
    `CDAU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result word changed")

    // an accepted word keeps the block busy in the next cycle
    `CDAU_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken again right after accept")

    // a failed word carries zero day of year and weekday
    `CDAU_ASSERT_IMP(a_fail_zeroed, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_OK), (o_out_data.ordinal_day == '0) && (o_out_data.weekday == '0), "failed result has nonzero ordinal or weekday")

    // a good word holds a date in range
    `CDAU_ASSERT_IMP(a_ok_range, i_clk, i_rst_n, o_out_valid && (o_out_data.status == ST_OK), (o_out_data.weekday <= WDAY_LAST) && (o_out_data.new_month != '0) && (o_out_data.new_month <= MONTHS) && (o_out_data.new_day != '0) && (o_out_data.ordinal_day <= ORD_LAST) && (o_out_data.new_year >= YEAR_MIN) && (o_out_data.new_year <= YEAR_MAX), "good result out of range")

endmodule

bind calendar_date_arithmetic_unit cdau_checker u_cdau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
